### sv/rsc_pkg.sv
// Shared constants for the rectangle versus segment collision test.
package rsc_pkg;

  localparam int RSC_COORD_WIDTH = 16;
  localparam int RSC_NUM_EDGES   = 4;

endpackage

### sv/rsc_if.sv
// Valid/ready channel interfaces for query items and hit items.
interface rsc_in_if
  import rsc_pkg::*;
#(
  parameter int W = RSC_COORD_WIDTH
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] corner_a_x;
  logic signed [W-1:0] corner_a_y;
  logic signed [W-1:0] corner_b_x;
  logic signed [W-1:0] corner_b_y;
  logic signed [W-1:0] corner_c_x;
  logic signed [W-1:0] corner_c_y;
  logic signed [W-1:0] corner_d_x;
  logic signed [W-1:0] corner_d_y;
  logic signed [W-1:0] seg_start_x;
  logic signed [W-1:0] seg_start_y;
  logic signed [W-1:0] seg_end_x;
  logic signed [W-1:0] seg_end_y;

  modport source (
    output valid, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
           corner_c_x, corner_c_y, corner_d_x, corner_d_y,
           seg_start_x, seg_start_y, seg_end_x, seg_end_y,
    input  ready
  );
  modport sink (
    input  valid, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
           corner_c_x, corner_c_y, corner_d_x, corner_d_y,
           seg_start_x, seg_start_y, seg_end_x, seg_end_y,
    output ready
  );
endinterface

interface rsc_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

### sv/rect_segment_collision_test.sv
// Top level of the rectangle versus line segment collision test.
//
// Usage:
//   in_ch carries one query item: four rectangle corners (top left, top
//   right, bottom right, bottom left, y up) and two segment endpoints, all
//   signed fixed point of COORD_WIDTH bits. out_ch returns one hit item per
//   query, in order. Both channels use valid/ready; an item moves when both
//   are high.
//   Pipeline: a query passes four register stages to its hit item
//   (differences, products, numerators and denominator, final compare
//   into the output register). Throughput: one item per cycle while out_ch
//   takes items; the 2*(COORD_WIDTH+1)-bit products of the second stage
//   set the clock, the rest of the path is shallow.
//   Stall: all stages advance together whenever the output register is
//   empty or being taken, so in_ch.ready follows out_ch.ready while the
//   output holds an item. A stall holds every stage; nothing is lost.
//   Reset: rst_n (synchronous, active low) clears all valid bits; the
//   pipeline is empty and ready in the first cycle after reset.
module rect_segment_collision_test
  import rsc_pkg::*;
#(
  parameter int COORD_WIDTH = RSC_COORD_WIDTH
) (
  input  logic     clk,
  input  logic     rst_n,
  rsc_in_if.sink   in_ch,
  rsc_out_if.source out_ch
);

  localparam int NE = RSC_NUM_EDGES;

  logic                          en;
  logic                          v1_r, v2_r, v3_r, out_valid_r;
  logic                          hit_nxt, hit_r;
  logic                          box_inside;
  logic [NE-1:0]                 edge_hit;
  logic signed [COORD_WIDTH-1:0] kx [NE];
  logic signed [COORD_WIDTH-1:0] ky [NE];

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  assign kx[0] = in_ch.corner_a_x;
  assign ky[0] = in_ch.corner_a_y;
  assign kx[1] = in_ch.corner_b_x;
  assign ky[1] = in_ch.corner_b_y;
  assign kx[2] = in_ch.corner_c_x;
  assign ky[2] = in_ch.corner_c_y;
  assign kx[3] = in_ch.corner_d_x;
  assign ky[3] = in_ch.corner_d_y;

  rsc_box_test #(.W(COORD_WIDTH)) u_box (
    .clk       (clk),
    .en        (en),
    .ax        (in_ch.corner_a_x),
    .ay        (in_ch.corner_a_y),
    .cx        (in_ch.corner_c_x),
    .cy        (in_ch.corner_c_y),
    .sx        (in_ch.seg_start_x),
    .sy        (in_ch.seg_start_y),
    .tx        (in_ch.seg_end_x),
    .ty        (in_ch.seg_end_y),
    .pt_in_box (box_inside)
  );

  for (genvar i = 0; i < NE; i++) begin : g_edge
    localparam int J = (i + 1) % NE;
    rsc_edge_unit #(.W(COORD_WIDTH)) u_edge (
      .clk      (clk),
      .en       (en),
      .x1       (kx[i]),
      .y1       (ky[i]),
      .x2       (kx[J]),
      .y2       (ky[J]),
      .x3       (in_ch.seg_start_x),
      .y3       (in_ch.seg_start_y),
      .x4       (in_ch.seg_end_x),
      .y4       (in_ch.seg_end_y),
      .edge_hit (edge_hit[i])
    );
  end

  assign hit_nxt = box_inside || (|edge_hit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_ch.valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= hit_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.hit   = hit_r;

`ifndef SYNTH
  a_reset_empty : assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

  a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output register");

  a_stage_reaches_out : assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && en |=> out_ch.valid)
    else $error("item lost between last stage and output");

  a_stall_holds_stages : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $stable(v3_r) && $stable(hit_r))
    else $error("pipeline moved during stall");
`endif

endmodule

### sv/rsc_box_test.sv
// Endpoint-in-box test, delayed to line up with the edge pipeline.
module rsc_box_test
  import rsc_pkg::*;
#(
  parameter int W = RSC_COORD_WIDTH
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] ax,
  input  logic signed [W-1:0] ay,
  input  logic signed [W-1:0] cx,
  input  logic signed [W-1:0] cy,
  input  logic signed [W-1:0] sx,
  input  logic signed [W-1:0] sy,
  input  logic signed [W-1:0] tx,
  input  logic signed [W-1:0] ty,
  output logic                pt_in_box
);

  logic s_in_nxt, t_in_nxt;
  logic s_in_r, t_in_r;
  logic inside2_r, inside3_r;

  always_comb begin
    s_in_nxt = (sx >= ax) && (sx <= cx) && (sy <= ay) && (sy >= cy);
    t_in_nxt = (tx >= ax) && (tx <= cx) && (ty <= ay) && (ty >= cy);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_in_r    <= s_in_nxt;
      t_in_r    <= t_in_nxt;
      inside2_r <= s_in_r | t_in_r;
      inside3_r <= inside2_r;
    end
  end

  assign pt_in_box = inside3_r;

endmodule

### sv/rsc_edge_unit.sv
// Three-stage parametric edge versus segment test with exact ratio compare.
module rsc_edge_unit
  import rsc_pkg::*;
#(
  parameter int W = RSC_COORD_WIDTH
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] x1,
  input  logic signed [W-1:0] y1,
  input  logic signed [W-1:0] x2,
  input  logic signed [W-1:0] y2,
  input  logic signed [W-1:0] x3,
  input  logic signed [W-1:0] y3,
  input  logic signed [W-1:0] x4,
  input  logic signed [W-1:0] y4,
  output logic                edge_hit
);

  localparam int DW = W + 1;
  localparam int PW = 2 * DW;
  localparam int NW = 2 * W + 3;
  localparam int CW = NW + 1;

  logic signed [DW-1:0] ex_nxt, ey_nxt, sx_nxt, sy_nxt, ox_nxt, oy_nxt;
  logic signed [DW-1:0] ex_r, ey_r, sx_r, sy_r, ox_r, oy_r;
  logic signed [PW-1:0] syex_nxt, sxey_nxt, sxoy_nxt, syox_nxt, exoy_nxt, eyox_nxt;
  logic signed [PW-1:0] syex_r, sxey_r, sxoy_r, syox_r, exoy_r, eyox_r;
  logic signed [NW-1:0] den_nxt, n1_nxt, n2_nxt;
  logic signed [NW-1:0] den_r, n1_r, n2_r;

  function automatic logic in_unit(input logic signed [NW-1:0] n,
                                   input logic signed [NW-1:0] den);
    logic signed [CW-1:0] dn;
    logic signed [CW-1:0] nd;
    dn = CW'(den) - CW'(n);
    nd = CW'(n) - CW'(den);
    if (!den[NW-1]) begin
      in_unit = !n[NW-1] && !dn[CW-1];
    end else begin
      in_unit = (n[NW-1] || (n == '0)) && !nd[CW-1];
    end
  endfunction

  // stage 1: edge, segment and offset vectors
  always_comb begin
    ex_nxt = DW'(x2) - DW'(x1);
    ey_nxt = DW'(y2) - DW'(y1);
    sx_nxt = DW'(x4) - DW'(x3);
    sy_nxt = DW'(y4) - DW'(y3);
    ox_nxt = DW'(x1) - DW'(x3);
    oy_nxt = DW'(y1) - DW'(y3);
  end

  // stage 2: cross products
  always_comb begin
    syex_nxt = PW'(sy_r) * PW'(ex_r);
    sxey_nxt = PW'(sx_r) * PW'(ey_r);
    sxoy_nxt = PW'(sx_r) * PW'(oy_r);
    syox_nxt = PW'(sy_r) * PW'(ox_r);
    exoy_nxt = PW'(ex_r) * PW'(oy_r);
    eyox_nxt = PW'(ey_r) * PW'(ox_r);
  end

  // stage 3: denominator and numerators
  always_comb begin
    den_nxt = NW'(syex_r) - NW'(sxey_r);
    n1_nxt  = NW'(sxoy_r) - NW'(syox_r);
    n2_nxt  = NW'(exoy_r) - NW'(eyox_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ex_r   <= ex_nxt;
      ey_r   <= ey_nxt;
      sx_r   <= sx_nxt;
      sy_r   <= sy_nxt;
      ox_r   <= ox_nxt;
      oy_r   <= oy_nxt;
      syex_r <= syex_nxt;
      sxey_r <= sxey_nxt;
      sxoy_r <= sxoy_nxt;
      syox_r <= syox_nxt;
      exoy_r <= exoy_nxt;
      eyox_r <= eyox_nxt;
      den_r  <= den_nxt;
      n1_r   <= n1_nxt;
      n2_r   <= n2_nxt;
    end
  end

  // drop parallel edges; keep 0 <= t, u <= 1
  assign edge_hit = (den_r != '0) && in_unit(n1_r, den_r) && in_unit(n2_r, den_r);

endmodule
